>>> hdl/feedback_comb_echo_unit_macros.svh
// Assertion macros shared by the echo unit RTL.
`ifndef FEEDBACK_COMB_ECHO_UNIT_MACROS_SVH
`define FEEDBACK_COMB_ECHO_UNIT_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define FCE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define FCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/fce_pkg.sv
// Types and constants of the feedback comb echo unit.
`default_nettype none

package fce_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int DLEN_W   = 13;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [GAIN_W-1:0] gain_t;
	typedef logic [DLEN_W-1:0] dlen_t;
	typedef logic [0:0] reg_idx_t;

	// Register indexes, one word apart on the configuration port.
	localparam reg_idx_t REG_DELAY_LENGTH = 1'b0;
	localparam reg_idx_t REG_DECAY_GAIN   = 1'b1;

	localparam dlen_t DELAY_LENGTH_RESET = 13'd4000;
	localparam gain_t DECAY_GAIN_RESET   = 16'd39322;

	localparam sample_t SAMPLE_MAX = 16'sh7FFF;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

endpackage

`default_nettype wire

>>> hdl/fce_if.sv
// Sample stream interfaces of the echo unit.
`default_nettype none

interface fce_smp_in_if;
	logic                    valid;
	logic                    ready;
	logic signed [fce_pkg::SAMPLE_W-1:0] sample_in;
	logic                    first_of_block;

	modport source (output valid, output sample_in, output first_of_block, input ready);
	modport sink (input valid, input sample_in, input first_of_block, output ready);
endinterface

interface fce_smp_out_if;
	logic                    valid;
	logic                    ready;
	logic signed [fce_pkg::SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

>>> hdl/feedback_comb_echo_unit.sv
// Top level of the feedback comb echo unit.
//
// Usage: samples arrive on smp_in (valid/ready) with a first_of_block flag,
// and one echoed sample leaves on smp_out per request, in order. Each result
// is y = x + gain * d, where d is the unit's own output delay_length samples
// earlier, truncated toward zero and saturated to signed 16 bit.
// An accepted request waits in stage one for its RAM read; its result is
// registered for smp_out. Throughput is one sample per cycle unless smp_out
// stalls: the delay line is a RAM with a registered read, read at accept and
// written back as stage one advances; a write and a read of the same entry
// in one cycle are bypassed from a register. A first-of-block request empties
// the delay line at once: a fill count marks the entries written since, and
// all others read as zero, so no clearing pass is needed after reset either.
// Reset sets delay_length to 4000, decay_gain to 39322, the ring position to
// zero and an empty delay line. When smp_out stalls, the output register
// holds and smp_in drops ready until the result is taken.
// The user must write registers over APB only while idle; the unit does not enforce it.
`include "feedback_comb_echo_unit_macros.svh"
`default_nettype none

module feedback_comb_echo_unit #(
	parameter int MAX_DELAY = 4096
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [fce_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire logic [fce_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic      [fce_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                                  pready,
	fce_smp_in_if.sink                            smp_in,
	fce_smp_out_if.source                         smp_out
);

	localparam int AW = $clog2(MAX_DELAY);
	localparam int LW = $clog2(MAX_DELAY + 1);

	// Configuration registers.
	fce_pkg::dlen_t delay_length_q;
	fce_pkg::gain_t decay_gain_q;
	fce_pkg::reg_idx_t reg_idx;
	logic cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q <= fce_pkg::DELAY_LENGTH_RESET;
			decay_gain_q   <= fce_pkg::DECAY_GAIN_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				fce_pkg::REG_DELAY_LENGTH: delay_length_q <= pwdata[fce_pkg::DLEN_W-1:0];
				fce_pkg::REG_DECAY_GAIN:   decay_gain_q   <= pwdata[fce_pkg::GAIN_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			fce_pkg::REG_DELAY_LENGTH: prdata = 32'(delay_length_q);
			fce_pkg::REG_DECAY_GAIN:   prdata = 32'(decay_gain_q);
		endcase
	end

	// Effective ring length: zero acts as one, and it never exceeds the store.
	logic [31:0]   dl_ext;
	logic [31:0]   len_ext;
	logic [LW-1:0] ring_len;

	always_comb begin
		dl_ext = 32'(delay_length_q);
		if (dl_ext == 32'd0) begin
			len_ext = 32'd1;
		end else if (dl_ext > 32'(MAX_DELAY)) begin
			len_ext = 32'(MAX_DELAY);
		end else begin
			len_ext = dl_ext;
		end
		ring_len = len_ext[LW-1:0];
	end

	// Handshake: the pipeline moves whenever the output register is free.
	logic advance;
	logic acc;
	logic valid_s1;
	logic out_valid_q;

	assign advance      = !out_valid_q || smp_out.ready;
	assign smp_in.ready = advance;
	assign acc          = smp_in.valid && advance;

	// Ring position and fill count, updated as each request is accepted.
	logic [AW-1:0] pos_q;
	logic [LW-1:0] fill_q;
	logic [AW-1:0] p_base;
	logic [LW-1:0] p_base_w;
	logic [LW-1:0] p_eff_w;
	logic [AW-1:0] p_eff;
	logic [LW:0]   p_inc;
	logic [AW-1:0] pos_next;
	logic [LW-1:0] fill_base;
	logic [LW-1:0] fill_next;
	logic          rd_valid;

	always_comb begin
		p_base    = smp_in.first_of_block ? '0 : pos_q;
		fill_base = smp_in.first_of_block ? '0 : fill_q;
		p_base_w  = LW'(p_base);
		p_eff_w   = (p_base_w >= ring_len) ? '0 : p_base_w;
		p_eff     = p_eff_w[AW-1:0];
		p_inc     = (LW + 1)'(p_eff_w) + 1'b1;
		pos_next  = (p_inc >= (LW + 1)'(ring_len)) ? '0 : p_inc[AW-1:0];
		// Entries below the fill count were written since the last clear.
		rd_valid  = p_eff_w < fill_base;
		fill_next = (p_eff_w == fill_base) ? LW'(fill_base + 1'b1) : fill_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
		end else if (acc) begin
			pos_q  <= pos_next;
			fill_q <= fill_next;
		end
	end

	// Stage one: request waiting for its RAM read data.
	fce_pkg::sample_t sample_s1;
	logic [AW-1:0]    p_s1;
	logic             rd_valid_s1;
	logic             fwd_s1;
	fce_pkg::sample_t last_wr_q;
	fce_pkg::sample_t y;
	logic             ram_we;
	logic [fce_pkg::SAMPLE_W-1:0] ram_rdata;

	assign ram_we = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= smp_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sample_s1   <= smp_in.sample_in;
			p_s1        <= p_eff;
			rd_valid_s1 <= rd_valid;
			// The RAM misses a write to the same entry in the cycle of the read.
			fwd_s1      <= ram_we && (p_s1 == p_eff);
		end
		if (ram_we) begin
			last_wr_q <= y;
		end
	end

	fce_ram #(
		.WIDTH(fce_pkg::SAMPLE_W),
		.DEPTH(MAX_DELAY)
	) u_delay_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(p_s1),
		.wdata(y),
		.re   (acc),
		.raddr(p_eff),
		.rdata(ram_rdata)
	);

	// Feedback arithmetic: x + gain * d, truncated toward zero, saturated.
	fce_pkg::sample_t     d;
	logic signed [32:0]   prod;
	logic signed [33:0]   sum;
	logic signed [17:0]   quot;
	logic                 corr;
	logic signed [18:0]   quot_c;

	always_comb begin
		if (!rd_valid_s1) begin
			d = '0;
		end else if (fwd_s1) begin
			d = last_wr_q;
		end else begin
			d = $signed(ram_rdata);
		end
		prod   = $signed({1'b0, decay_gain_q}) * d;
		sum    = $signed({{2{sample_s1[15]}}, sample_s1, 16'b0}) + $signed({prod[32], prod});
		quot   = sum[33:16];
		corr   = sum[33] && (sum[15:0] != 16'b0);
		quot_c = $signed({quot[17], quot}) + $signed({18'b0, corr});
		if (quot_c > 19'sd32767) begin
			y = fce_pkg::SAMPLE_MAX;
		end else if (quot_c < -19'sd32768) begin
			y = fce_pkg::SAMPLE_MIN;
		end else begin
			y = quot_c[15:0];
		end
	end

	// Output register.
	fce_pkg::sample_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			out_q <= y;
		end
	end

	assign smp_out.valid      = out_valid_q;
	assign smp_out.sample_out = out_q;

	// Assertions on the ring bookkeeping and the pipeline.
	`FCE_ASSERT_SAME(a_pos_within_fill, 1'b1, LW'(pos_q) <= fill_q, "ring position past fill count")
	`FCE_ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= LW'(MAX_DELAY), "fill count beyond store")
	`FCE_ASSERT_NEXT(a_first_reads_zero, acc && smp_in.first_of_block, !rd_valid_s1, "cleared entry read as valid")
	`FCE_ASSERT_NEXT(a_stage_to_output, valid_s1 && advance, out_valid_q, "result lost between stages")

endmodule

`default_nettype wire

>>> hdl/fce_ram.sv
// Generic simple dual-port RAM with a registered read.
`default_nettype none

module fce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> tb/fce_echo_compare.sv
// Echo predictor and result comparison for the feedback comb echo unit.
module fce_echo_compare
	import fce_pkg::*;
#(
	parameter int MAX_DELAY = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	fce_smp_in_if                 smp_in,
	fce_smp_out_if                smp_out,
	output int                    mismatches,
	output int                    echoes_seen,
	output int                    echoes_owed
);

	// Shadow of the unit's registers and delay line.
	dlen_t       echo_delay;
	gain_t       echo_gain;
	sample_t     echo_line [MAX_DELAY];
	int unsigned tap;
	sample_t     owed_echoes [$];
	int          fails;
	int          seen;

	// Works out the echoed sample for one request and updates the delay line.
	function automatic sample_t next_echo(input sample_t dry, input logic restart);
		int unsigned span;
		longint acc;
		longint wet;
		// A zero delay acts as one, a delay past the store acts as the full store.
		if (echo_delay == '0)
			span = 1;
		else if (echo_delay > MAX_DELAY)
			span = MAX_DELAY;
		else
			span = 32'(echo_delay);
		if (restart) begin
			foreach (echo_line[i]) echo_line[i] = '0;
			tap = 0;
		end
		// A delay lowered below the current position restarts the ring.
		if (tap >= span)
			tap = 0;
		acc = longint'(dry) * 65536 + longint'(echo_gain) * longint'(echo_line[tap]);
		wet = acc / 65536;
		if (wet > longint'(SAMPLE_MAX))
			wet = longint'(SAMPLE_MAX);
		if (wet < longint'(SAMPLE_MIN))
			wet = longint'(SAMPLE_MIN);
		echo_line[tap] = sample_t'(wet);
		tap++;
		if (tap >= span)
			tap = 0;
		return sample_t'(wet);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t want;
		if (!arst_n) begin
			echo_delay = DELAY_LENGTH_RESET;
			echo_gain = DECAY_GAIN_RESET;
			foreach (echo_line[i]) echo_line[i] = '0;
			tap = 0;
			owed_echoes.delete();
			fails = 0;
			seen = 0;
		end else begin
			// Register writes take effect at the access cycle.
			if (psel && penable && pwrite && pready) begin
				if (paddr[CFG_ADDR_W-1:2] == REG_DELAY_LENGTH)
					echo_delay = pwdata[DLEN_W-1:0];
				else if (paddr[CFG_ADDR_W-1:2] == REG_DECAY_GAIN)
					echo_gain = pwdata[GAIN_W-1:0];
			end

			// Every accepted request owes exactly one echoed sample.
			if (smp_in.valid && smp_in.ready)
				owed_echoes.push_back(next_echo(smp_in.sample_in, smp_in.first_of_block));

			// Results must come back in request order.
			if (smp_out.valid && smp_out.ready) begin
				seen++;
				if (owed_echoes.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("Result %0d arrived with no request pending: got %0d",
							seen, smp_out.sample_out);
				end else begin
					want = owed_echoes.pop_front();
					if (smp_out.sample_out !== want) begin
						fails++;
						if (fails <= 10)
							$display("Result %0d sample_out mismatch: expected %0d, got %0d",
								seen, want, smp_out.sample_out);
					end
				end
			end
		end
		mismatches <= fails;
		echoes_seen <= seen;
		echoes_owed <= owed_echoes.size();
	end

endmodule

>>> tb/feedback_comb_echo_unit_test.sv
// Stimulus, flow control and verdict for the feedback comb echo unit.
module feedback_comb_echo_unit_test;
	import fce_pkg::*;

	localparam int MAX_DELAY = 4096;
	localparam int RUN_LIMIT = 500000;
	localparam int RANDOM_REQUESTS = 950;
	localparam int LONG_HOLD = 80;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	int mismatches;
	int echoes_seen;
	int echoes_owed;

	fce_smp_in_if  smp_in ();
	fce_smp_out_if smp_out ();

	feedback_comb_echo_unit #(
		.MAX_DELAY(MAX_DELAY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.smp_in(smp_in),
		.smp_out(smp_out)
	);

	fce_echo_compare #(
		.MAX_DELAY(MAX_DELAY)
	) echo_compare (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.smp_in(smp_in),
		.smp_out(smp_out),
		.mismatches(mismatches),
		.echoes_seen(echoes_seen),
		.echoes_owed(echoes_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: ready follows one of four stall patterns, picked anew at random, and a
	// long hold-off is served whenever the stimulus asks for one.
	int          hold_asked = 0;
	int          hold_served = 0;
	int          hold_left = 0;
	int          rx_cycle = 0;
	stall_mode_e rx_mode = STALL_NONE;

	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 64 == 0)
			rx_mode = stall_mode_e'($urandom_range(0, 3));
		if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			smp_out.ready <= 1'b0;
		end else begin
			case (rx_mode)
				STALL_NONE: smp_out.ready <= 1'b1;
				STALL_LIGHT: smp_out.ready <= ($urandom_range(0, 3) != 0);
				STALL_HEAVY: smp_out.ready <= ($urandom_range(0, 3) == 0);
				default: smp_out.ready <= rx_cycle[0];
			endcase
		end
	end

	// Sender: requests go out in bursts of random length with random gaps.
	int burst_left = 0;
	int sent = 0;
	int restarts = 0;
	int writes = 0;

	task automatic send_sample(input sample_t dry, input logic restart);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				smp_in.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		smp_in.valid <= 1'b1;
		smp_in.sample_in <= dry;
		smp_in.first_of_block <= restart;
		do @(posedge clk); while (!smp_in.ready);
		sent++;
		if (restart)
			restarts++;
	endtask

	// Registers change only once the unit has returned every echo.
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		smp_in.valid <= 1'b0;
		@(posedge clk);
		while (echoes_owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		writes++;
	endtask

	// Watchdog: a run that outlasts the limit fails.
	int cycle_count = 0;

	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d echoes still owed.",
			cycle_count, echoes_owed);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int          phase_no;
		int          pick;
		int          phase_len;
		int          random_sent;
		int          k;
		dlen_t       span;
		gain_t       gain;
		sample_t     dry;
		logic        restart;

		smp_in.valid = 1'b0;
		smp_in.sample_in = '0;
		smp_in.first_of_block = 1'b0;
		smp_out.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the echo is far away, so samples pass straight through.
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample('0, 1'b0);
		send_sample(-16'sd1, 1'b0);

		// Full gain on a short ring drives the feedback into both rails.
		write_reg(REG_DELAY_LENGTH, {19'($urandom), 13'd3});
		write_reg(REG_DECAY_GAIN, {16'($urandom), 16'hFFFF});
		for (k = 0; k < 4; k++)
			send_sample(SAMPLE_MAX, k == 0);
		for (k = 0; k < 7; k++)
			send_sample(SAMPLE_MIN, 1'b0);

		// Shrinking the delay below the ring position wraps the ring early.
		write_reg(REG_DELAY_LENGTH, {19'($urandom), 13'd8});
		write_reg(REG_DECAY_GAIN, {16'($urandom), 16'h8000});
		for (k = 0; k < 6; k++)
			send_sample(k[0] ? -16'sd1001 : 16'sd1001, k == 0);
		write_reg(REG_DELAY_LENGTH, {19'($urandom), 13'd4});
		for (k = 0; k < 3; k++)
			send_sample(-16'sd777, 1'b0);

		// A zero delay behaves as one sample of delay.
		write_reg(REG_DELAY_LENGTH, {19'($urandom), 13'd0});
		write_reg(REG_DECAY_GAIN, {16'($urandom), 16'hFFFF});
		send_sample(16'sd12345, 1'b0);
		send_sample(-16'sd321, 1'b0);

		// A delay beyond the store is clamped to the store, here with no feedback.
		write_reg(REG_DELAY_LENGTH, {19'($urandom), 13'h1FFF});
		write_reg(REG_DECAY_GAIN, {16'($urandom), 16'h0000});
		send_sample(16'sd4660, 1'b0);
		send_sample(-16'sd4660, 1'b1);

		// Random phases, each under its own settings.
		random_sent = 0;
		phase_no = 0;
		while (random_sent < RANDOM_REQUESTS) begin
			case (phase_no)
				0: span = 13'd1;
				1: span = 13'(MAX_DELAY);
				default: begin
					pick = $urandom_range(0, 19);
					if (pick < 14)
						span = 13'($urandom_range(1, 40));
					else if (pick < 17)
						span = 13'($urandom_range(41, 600));
					else if (pick == 17)
						span = '0;
					else
						span = 13'($urandom_range(MAX_DELAY, 2**DLEN_W - 1));
				end
			endcase
			pick = $urandom_range(0, 9);
			if (pick < 2)
				gain = '1;
			else if (pick == 2)
				gain = '0;
			else
				gain = 16'($urandom);
			write_reg(REG_DELAY_LENGTH, {19'($urandom), span});
			write_reg(REG_DECAY_GAIN, {16'($urandom), gain});

			// Now and then the receiver holds off long enough to back up the unit.
			if (phase_no % 4 == 1)
				hold_asked++;

			phase_len = $urandom_range(60, 150);
			for (k = 0; k < phase_len && random_sent < RANDOM_REQUESTS; k++) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					dry = sample_t'($urandom);
				else if (pick < 8)
					dry = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
				else
					dry = sample_t'($urandom_range(0, 511)) - 16'sd256;
				restart = (k == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 49) == 0);
				send_sample(dry, restart);
				random_sent++;
			end
			phase_no++;
		end

		// Drain the unit before the verdict.
		smp_in.valid <= 1'b0;
		@(posedge clk);
		while (echoes_owed != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Drove %0d requests, %0d of them block restarts, across %0d register writes.",
			sent, restarts, writes);
		$display("Checked %0d echoed samples; %0d did not match.", echoes_seen, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
